// ----- rtl/rcmyk_pkg.sv -----
// ----------------------------------------------------------------------------
// rcmyk_pkg
// shared widths, constants and payload types of the rgb to cmyk separator
// ----------------------------------------------------------------------------
package rcmyk_pkg;

  localparam int unsigned PIX_W = 8;
  // dividend and divisor widths of the restoring dividers
  localparam int unsigned NUM_W = 16;
  localparam int unsigned DEN_W = 8;

  localparam logic [PIX_W-1:0] FULL_SCALE      = 8'd255;
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = 8'd127;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [PIX_W-1:0] cyan_deep;
    logic [PIX_W-1:0] magenta_deep;
    logic [PIX_W-1:0] yellow_plane;
    logic [PIX_W-1:0] black_deep;
    logic [PIX_W-1:0] cyan_light;
    logic [PIX_W-1:0] magenta_light;
    logic [PIX_W-1:0] black_light;
  } sep_t;

endpackage

// ----- rtl/rcmyk_pix_if.sv -----
// ----------------------------------------------------------------------------
// rcmyk_pix_if
// valid/ready channel carrying one rgb pixel per beat
// ----------------------------------------------------------------------------
interface rcmyk_pix_if;

  logic                        valid;
  logic                        ready;
  logic [rcmyk_pkg::PIX_W-1:0] red;
  logic [rcmyk_pkg::PIX_W-1:0] green;
  logic [rcmyk_pkg::PIX_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ----- rtl/rcmyk_sep_if.sv -----
// ----------------------------------------------------------------------------
// rcmyk_sep_if
// valid/ready channel carrying the seven ink planes of one pixel per beat
// ----------------------------------------------------------------------------
interface rcmyk_sep_if;

  logic                        valid;
  logic                        ready;
  logic [rcmyk_pkg::PIX_W-1:0] cyan_deep;
  logic [rcmyk_pkg::PIX_W-1:0] magenta_deep;
  logic [rcmyk_pkg::PIX_W-1:0] yellow_plane;
  logic [rcmyk_pkg::PIX_W-1:0] black_deep;
  logic [rcmyk_pkg::PIX_W-1:0] cyan_light;
  logic [rcmyk_pkg::PIX_W-1:0] magenta_light;
  logic [rcmyk_pkg::PIX_W-1:0] black_light;

  modport source (
    output valid, output cyan_deep, output magenta_deep, output yellow_plane,
    output black_deep, output cyan_light, output magenta_light, output black_light,
    input ready
  );
  modport sink (
    input valid, input cyan_deep, input magenta_deep, input yellow_plane,
    input black_deep, input cyan_light, input magenta_light, input black_light,
    output ready
  );

endinterface

// ----- rtl/rgb_to_cmyk_light_deep_split_top.sv -----
// ----------------------------------------------------------------------------
// rgb_to_cmyk_light_deep_split_top
// rgb pixel to seven ink planes with light/deep split of cyan, magenta, black
// ----------------------------------------------------------------------------
// Takes one rgb pixel per beat and returns one beat of seven 8-bit planes:
// deep and light cyan, magenta and black, and raw yellow. A pixel can enter
// every cycle while the output is ready. Each pixel passes the prep stage,
// the 8-stage raw chroma divider, the remap stage, the 8-stage remap
// divider and the output register. The two restoring dividers give one
// quotient bit per stage and set their depth. A stall on the output
// backs up stage by stage, empty stages keep filling, nothing is dropped.
// The split threshold (reset 127) is written through cfg_we_i/cfg_wdata_i
// and applies to every pixel accepted afterwards; write it only while no
// pixel is in flight. No clearing pass after reset.
// ----------------------------------------------------------------------------
module rgb_to_cmyk_light_deep_split_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [rcmyk_pkg::PIX_W-1:0] cfg_wdata_i,
  rcmyk_pix_if.sink                   pix_i,
  rcmyk_sep_if.source                 sep_o
);

  localparam int unsigned W     = rcmyk_pkg::PIX_W;
  localparam int unsigned NUM_W = rcmyk_pkg::NUM_W;
  localparam int unsigned DEN_W = rcmyk_pkg::DEN_W;
  localparam int unsigned Q_W   = NUM_W - DEN_W;

  // remap stage sideband: raw yellow, above-threshold flags and raw values
  // of cyan, magenta, black (lane 0, 1, 2)
  typedef struct packed {
    logic [W-1:0]      y;
    logic [2:0]        gt;
    logic [2:0][W-1:0] v;
  } remap_side_t;

  localparam int unsigned SIDE_A_W = 1 + W;
  localparam int unsigned SIDE_B_W = $bits(remap_side_t);

  // split threshold register
  logic [W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rcmyk_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // --------------------------------------------------------------------------
  // prep stage: max, chroma numerators (mx - ch) * 255, raw black
  // --------------------------------------------------------------------------
  logic                   p_en;
  logic                   p_valid_q;
  logic [2:0][NUM_W-1:0]  p_num_q, p_num_d;
  logic [W-1:0]           p_mx_q, p_mx_d;
  logic [W-1:0]           p_k_q, p_k_d;
  logic                   p_blk_q;
  logic                   a_in_ready;
  rcmyk_pkg::pixel_t      pix;

  assign pix = '{red: pix_i.red, green: pix_i.green, blue: pix_i.blue};

  always_comb begin
    logic [W-1:0] diff;
    p_mx_d = pix.red;
    if (pix.green > p_mx_d) begin
      p_mx_d = pix.green;
    end
    if (pix.blue > p_mx_d) begin
      p_mx_d = pix.blue;
    end
    // x * 255 as (x << 8) - x
    diff       = p_mx_d - pix.red;
    p_num_d[0] = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
    diff       = p_mx_d - pix.green;
    p_num_d[1] = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
    diff       = p_mx_d - pix.blue;
    p_num_d[2] = {diff, {W{1'b0}}} - {{W{1'b0}}, diff};
    p_k_d      = rcmyk_pkg::FULL_SCALE - p_mx_d;
  end

  assign p_en        = !p_valid_q || a_in_ready;
  assign pix_i.ready = p_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (p_en) begin
      p_valid_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_en && pix_i.valid) begin
      p_num_q <= p_num_d;
      p_mx_q  <= p_mx_d;
      p_k_q   <= p_k_d;
      p_blk_q <= (p_mx_d == '0);
    end
  end

  // --------------------------------------------------------------------------
  // raw chroma divider: three lanes over the same divisor mx
  // --------------------------------------------------------------------------
  logic                   a_out_valid;
  logic                   a_out_ready;
  logic [2:0][Q_W-1:0]    a_quo;
  logic [SIDE_A_W-1:0]    a_side;
  logic [2:0][DEN_W-1:0]  a_den;

  assign a_den = {p_mx_q, p_mx_q, p_mx_q};

  rcmyk_div #(
    .LANES  (3),
    .SIDE_W (SIDE_A_W),
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W)
  ) u_div_raw (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p_valid_q),
    .in_ready_o  (a_in_ready),
    .num_i       (p_num_q),
    .den_i       (a_den),
    .side_i      ({p_blk_q, p_k_q}),
    .out_valid_o (a_out_valid),
    .out_ready_i (a_out_ready),
    .quo_o       (a_quo),
    .side_o      (a_side)
  );

  // --------------------------------------------------------------------------
  // remap stage: threshold compare and numerators of deep and light planes
  // lanes 0..2 deep, 3..5 light, 6 gives floor(255 / t)
  // --------------------------------------------------------------------------
  logic                   s_en;
  logic                   s_valid_q;
  logic [6:0][NUM_W-1:0]  s_num_q, s_num_d;
  remap_side_t            s_side_q, s_side_d;
  logic [6:0][DEN_W-1:0]  b_den;
  logic                   b_in_ready;

  always_comb begin
    logic         blk;
    logic [W-1:0] dd;
    logic [W-1:0] dl;
    blk          = a_side[W];
    // black pixel gives zero raw chroma
    s_side_d.v[0] = blk ? '0 : a_quo[0];
    s_side_d.v[1] = blk ? '0 : a_quo[1];
    s_side_d.y    = blk ? '0 : a_quo[2];
    s_side_d.v[2] = a_side[W-1:0];
    for (int i = 0; i < 3; i++) begin
      s_side_d.gt[i] = (s_side_d.v[i] > thr_q);
      dd             = s_side_d.v[i] - thr_q;
      dl             = ~s_side_d.v[i];
      s_num_d[i]     = {dd, {W{1'b0}}} - {{W{1'b0}}, dd};
      s_num_d[i+3]   = {dl, {W{1'b0}}} - {{W{1'b0}}, dl};
    end
    s_num_d[6] = {{W{1'b0}}, rcmyk_pkg::FULL_SCALE};
  end

  assign s_en        = !s_valid_q || b_in_ready;
  assign a_out_ready = s_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (s_en) begin
      s_valid_q <= a_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_en && a_out_valid) begin
      s_num_q  <= s_num_d;
      s_side_q <= s_side_d;
    end
  end

  // divisor 255 - t for the remap lanes, t for the light scale lane;
  // the user must hold the threshold steady while pixels are in flight; not enforced
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      b_den[i] = rcmyk_pkg::FULL_SCALE - thr_q;
    end
    b_den[6] = thr_q;
  end

  // --------------------------------------------------------------------------
  // remap divider
  // --------------------------------------------------------------------------
  logic                   b_out_valid;
  logic                   b_out_ready;
  logic [6:0][Q_W-1:0]    b_quo;
  logic [SIDE_B_W-1:0]    b_side;
  remap_side_t            b_info;

  rcmyk_div #(
    .LANES  (7),
    .SIDE_W (SIDE_B_W),
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W)
  ) u_div_remap (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_valid_q),
    .in_ready_o  (b_in_ready),
    .num_i       (s_num_q),
    .den_i       (b_den),
    .side_i      (s_side_q),
    .out_valid_o (b_out_valid),
    .out_ready_i (b_out_ready),
    .quo_o       (b_quo),
    .side_o      (b_side)
  );

  assign b_info = remap_side_t'(b_side);

  // --------------------------------------------------------------------------
  // output stage: pick deep/light branch, low range is v * floor(255 / t)
  // --------------------------------------------------------------------------
  logic                o_en;
  logic                o_valid_q;
  rcmyk_pkg::sep_t     o_data_q, o_data_d;
  logic [2:0][W-1:0]   deep, light;

  always_comb begin
    logic [2*W-1:0] prod;
    for (int i = 0; i < 3; i++) begin
      prod     = b_info.v[i] * b_quo[6];
      deep[i]  = b_info.gt[i] ? b_quo[i] : '0;
      // zero threshold: a zero raw value stays zero
      light[i] = b_info.gt[i] ? b_quo[i+3] : ((thr_q == '0) ? '0 : prod[W-1:0]);
    end
    o_data_d.cyan_deep     = deep[0];
    o_data_d.magenta_deep  = deep[1];
    o_data_d.yellow_plane  = b_info.y;
    o_data_d.black_deep    = deep[2];
    o_data_d.cyan_light    = light[0];
    o_data_d.magenta_light = light[1];
    o_data_d.black_light   = light[2];
  end

  // output register parts the output handshake from the pipeline
  assign o_en        = !o_valid_q || sep_o.ready;
  assign b_out_ready = o_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (o_en) begin
      o_valid_q <= b_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (o_en && b_out_valid) begin
      o_data_q <= o_data_d;
    end
  end

  assign sep_o.valid         = o_valid_q;
  assign sep_o.cyan_deep     = o_data_q.cyan_deep;
  assign sep_o.magenta_deep  = o_data_q.magenta_deep;
  assign sep_o.yellow_plane  = o_data_q.yellow_plane;
  assign sep_o.black_deep    = o_data_q.black_deep;
  assign sep_o.cyan_light    = o_data_q.cyan_light;
  assign sep_o.magenta_light = o_data_q.magenta_light;
  assign sep_o.black_light   = o_data_q.black_light;

endmodule

// ----- rtl/rcmyk_div.sv -----
// ----------------------------------------------------------------------------
// rcmyk_div
// pipelined restoring divider, several lanes, one quotient bit per stage
// ----------------------------------------------------------------------------
module rcmyk_div #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned SIDE_W = 1,
  parameter int unsigned NUM_W  = rcmyk_pkg::NUM_W,
  parameter int unsigned DEN_W  = rcmyk_pkg::DEN_W
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [LANES-1:0][NUM_W-1:0]             num_i,
  input  logic [LANES-1:0][DEN_W-1:0]             den_i,
  input  logic [SIDE_W-1:0]                       side_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [LANES-1:0][NUM_W-DEN_W-1:0]       quo_o,
  output logic [SIDE_W-1:0]                       side_o
);

  // quotient must fit in Q_W bits: num < den << Q_W
  localparam int unsigned Q_W = NUM_W - DEN_W;

  logic                               valid_q [Q_W];
  logic                               en      [Q_W];
  logic [LANES-1:0][NUM_W-1:0]        acc_q   [Q_W];
  logic [LANES-1:0][NUM_W-1:0]        acc_d   [Q_W];
  logic [LANES-1:0][DEN_W-1:0]        den_q   [Q_W];
  logic [SIDE_W-1:0]                  side_q  [Q_W];

  // upper bits hold the partial remainder, lower bits shift dividend out
  // and quotient in
  function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] acc,
                                                input logic [DEN_W-1:0] den);
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic [DEN_W-1:0] top;
    logic             qbit;
    trial = acc[NUM_W-1:Q_W-1];
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
    top   = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    return {top, acc[Q_W-2:0], qbit};
  endfunction

  // a stage moves when it is empty or the next one moves
  always_comb begin
    en[Q_W-1] = !valid_q[Q_W-1] || out_ready_i;
    for (int s = Q_W - 2; s >= 0; s--) begin
      en[s] = !valid_q[s] || en[s+1];
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic                        vin;
    logic [LANES-1:0][NUM_W-1:0] acc_in;
    logic [LANES-1:0][DEN_W-1:0] den_in;
    logic [SIDE_W-1:0]           side_in;

    if (s == 0) begin : g_first
      assign vin     = in_valid_i;
      assign acc_in  = num_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign vin     = valid_q[s-1];
      assign acc_in  = acc_q[s-1];
      assign den_in  = den_q[s-1];
      assign side_in = side_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        acc_d[s][l] = div_step(acc_in[l], den_in[l]);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en[s]) begin
        valid_q[s] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[s] && vin) begin
        acc_q[s]  <= acc_d[s];
        den_q[s]  <= den_in;
        side_q[s] <= side_in;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[Q_W-1];
  assign side_o      = side_q[Q_W-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      quo_o[l] = acc_q[Q_W-1][l][Q_W-1:0];
    end
  end

endmodule

// ----- rtl/rcmyk_chk.sv -----
// ----------------------------------------------------------------------------
// rcmyk_chk
// port-level checks of the separator handshakes and pipeline occupancy
// ----------------------------------------------------------------------------
module rcmyk_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pix_valid_i,
  input logic                        pix_ready_i,
  input logic                        sep_valid_i,
  input logic                        sep_ready_i,
  input logic [7*rcmyk_pkg::PIX_W-1:0] sep_data_i
);

  // prep + two dividers + remap + output register
  localparam int unsigned DEPTH = 3 + 2 * (rcmyk_pkg::NUM_W - rcmyk_pkg::DEN_W);
  localparam int unsigned OCC_W = $clog2(DEPTH + 1);

  logic             in_beat, out_beat;
  logic [OCC_W-1:0] occ_q, occ_d;

  assign in_beat  = pix_valid_i && pix_ready_i;
  assign out_beat = sep_valid_i && sep_ready_i;

  always_comb begin
    occ_d = occ_q;
    if (in_beat && !out_beat) begin
      occ_d = occ_q + 1'b1;
    end else if (!in_beat && out_beat) begin
      occ_d = occ_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_valid_i && !sep_ready_i |=> sep_valid_i)
    else $error("output beat withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_valid_i && !sep_ready_i |=> $stable(sep_data_i))
    else $error("output planes changed while stalled");

  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!sep_valid_i || sep_ready_i) |-> pix_ready_i)
    else $error("input blocked while output drains");

  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sep_valid_i |-> (occ_q != '0))
    else $error("output beat without a pixel in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(DEPTH))
    else $error("more pixels in flight than pipeline stages");

endmodule

bind rgb_to_cmyk_light_deep_split_top rcmyk_chk u_rcmyk_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .pix_valid_i (pix_i.valid),
  .pix_ready_i (pix_i.ready),
  .sep_valid_i (sep_o.valid),
  .sep_ready_i (sep_o.ready),
  .sep_data_i  ({sep_o.cyan_deep, sep_o.magenta_deep, sep_o.yellow_plane, sep_o.black_deep,
                 sep_o.cyan_light, sep_o.magenta_light, sep_o.black_light})
);
